FILE: rtl/isort_pkg.sv
// isort_pkg: shared sizes, controller states and the command and status
// structs that join the insertion sorter controller and datapath.
// No dependencies.
package isort_pkg;

	// store depth and derived widths
	localparam int MAX_ITEMS = 64;
	localparam int VAL_W     = 32;
	localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_PLACE,
		S_EM_RD,
		S_EM_LD
	} isort_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the incoming word, start at the end of the run
		logic drop;     // store full: mark the set as overflowed
		logic rd;       // read the entry just below the insert position
		logic shift;    // move the read entry up one place
		logic place;    // write the new value at the insert position
		logic em_rd;    // read the next entry to emit
		logic em_load;  // move the read entry into the output register
	} isort_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;       // store holds MAX_ITEMS entries
		logic empty;      // store holds nothing
		logic less;       // new value sorts before the entry read
		logic pos_one;    // insert position is one
		logic last;       // captured word closes the set
		logic final_idx;  // entry being emitted is the largest
		logic out_free;   // output register can take a word this cycle
	} isort_status_t;

endpackage

FILE: rtl/isort_if.sv
// isort_in_if / isort_out_if: valid-ready channels for the insertion sorter.
// Depends on isort_pkg for the value width.
interface isort_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [isort_pkg::VAL_W-1:0] value;
	logic                            last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [isort_pkg::VAL_W-1:0] sorted_value;
	logic                            final_res;
	logic                            overflow;

	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface

FILE: rtl/isort_dp.sv
// isort_dp: insertion sorter datapath: sorted store memory, insert position,
// fill count, overflow flag, emit index and the output register.
// Depends on isort_pkg.
module isort_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [isort_pkg::VAL_W-1:0] value,
	input  logic                             last,
	input  isort_pkg::isort_cmd_t            cmd,
	output isort_pkg::isort_status_t         status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [isort_pkg::VAL_W-1:0] sorted_value,
	output logic                             final_res,
	output logic                             overflow
);
	import isort_pkg::*;

	logic signed [VAL_W-1:0] mem [MAX_ITEMS];
	logic signed [VAL_W-1:0] rd_data_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    last_q;
	logic [ADDR_W-1:0]       pos_q;
	logic [ADDR_W-1:0]       idx_q;
	logic [CNT_W-1:0]        fill_q;
	logic                    flag_q;

	logic                    wr_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic signed [VAL_W-1:0] wr_data;
	logic                    final_idx;

	// memory address and data selection
	assign wr_en     = cmd.shift | cmd.place;
	assign wr_data   = cmd.shift ? rd_data_q : val_q;
	assign rd_addr   = cmd.em_rd ? idx_q : ADDR_W'(pos_q - ADDR_W'(1));
	assign final_idx = (CNT_W'(idx_q) + CNT_W'(1)) == fill_q;

	// sorted store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (cmd.rd | cmd.em_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// captured word and insert position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			pos_q  <= '0;
		end else if (cmd.load) begin
			last_q <= last;
			pos_q  <= fill_q[ADDR_W-1:0];
		end else if (cmd.shift) begin
			pos_q <= pos_q - ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
		end
	end

	// fill count, overflow flag and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			flag_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (cmd.place) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.drop) begin
				flag_q <= 1'b1;
			end
			if (cmd.em_load) begin
				if (final_idx) begin
					fill_q <= '0;
					flag_q <= 1'b0;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + ADDR_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.em_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.em_load) begin
			sorted_value <= rd_data_q;
			final_res    <= final_idx;
			overflow     <= flag_q;
		end
	end

	// status to the controller
	always_comb begin
		status.full      = fill_q == CNT_W'(MAX_ITEMS);
		status.empty     = fill_q == '0;
		status.less      = val_q < rd_data_q;
		status.pos_one   = pos_q == ADDR_W'(1);
		status.last      = last_q;
		status.final_idx = final_idx;
		status.out_free  = !out_valid || out_ready;
	end

endmodule

FILE: rtl/isort_ctrl.sv
// isort_ctrl: insertion sorter controller: takes a word, walks it down the
// stored run one compare at a time, then drives emission of the set.
// Depends on isort_pkg.
module isort_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     drop_last,
	input  isort_pkg::isort_status_t status,
	output isort_pkg::isort_cmd_t    cmd
);
	import isort_pkg::*;

	isort_state_t state_q;
	isort_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.full) begin
						cmd.drop = 1'b1;
						// a full store still empties on the closing word
						state_d  = drop_last ? S_EM_RD : S_IDLE;
					end else if (status.empty) begin
						state_d = S_PLACE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (status.less) begin
					cmd.shift = 1'b1;
					state_d   = status.pos_one ? S_PLACE : S_READ;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.place = 1'b1;
				state_d   = status.last ? S_EM_RD : S_IDLE;
			end
			S_EM_RD: begin
				cmd.em_rd = 1'b1;
				state_d   = S_EM_LD;
			end
			S_EM_LD: begin
				if (status.out_free) begin
					cmd.em_load = 1'b1;
					state_d     = status.final_idx ? S_IDLE : S_EM_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/insertion_sorter_top.sv
// insertion_sorter_top: stable ascending insertion sorter for sets of signed
// 32-bit words. Depends on isort_pkg, isort_if, isort_ctrl and isort_dp.
//
//   channel  dir  handshake     payload
//   din      in   valid/ready   value[31:0] signed, last
//   dout     out  valid/ready   sorted_value[31:0] signed, final_res, overflow
//
// Inserting a word walks it down the run: a read and a compare per stored
// entry that moves up, one more for the entry that stops the walk, if any,
// then a place. The single-port store and its registered read set this.
// A word dropped on a full store is not stored; a dropped closing word then
// emits. Each emitted word is read, then loaded, and may wait on output stall.
// No clearing pass: reset leaves an empty store. The next word is taken as
// soon as the last result of a set sits in the output register.
module insertion_sorter_top (
	input logic        clk,
	input logic        arst_n,
	isort_in_if.sink   din,
	isort_out_if.source dout
);
	import isort_pkg::*;

	isort_cmd_t    cmd;
	isort_status_t status;
	isort_status_t status_ctrl;
	logic          drop_last;

	// a dropped closing word goes straight to emission
	assign drop_last = din.last;

	always_comb begin
		status_ctrl      = status;
		status_ctrl.last = status.last;
	end

	isort_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.drop_last(drop_last),
		.status   (status_ctrl),
		.cmd      (cmd)
	);

	isort_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (din.value),
		.last         (din.last),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (dout.valid),
		.out_ready    (dout.ready),
		.sorted_value (dout.sorted_value),
		.final_res    (dout.final_res),
		.overflow     (dout.overflow)
	);

endmodule
